FILE: hdl/grfa_pkg.sv
// Shared types and constants for the grid rectangle first-fit allocator.
// No dependencies; the top level takes everything by scoped name.
package grfa_pkg;

    // Default sizing of the occupancy store.
    localparam int MAX_GRID_COLS_DEF = 64;
    localparam int MAX_GRID_ROWS_DEF = 64;

    // Field widths fixed by the interface.
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 1;
    localparam int SIZE_W      = 7;
    localparam int CORNER_W    = 6;
    localparam int ROW_CNT_W   = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_COLUMNS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_ROWS    = 1'b1;

    // Request codes.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_W-1:0] GRID_COLUMNS_RST = 7'd64;
    localparam logic [CFG_DATA_W-1:0] GRID_ROWS_RST    = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_SHIFT,
        ST_PICK,
        ST_MARK,
        ST_RESULT
    } t_state;

endpackage

FILE: hdl/grid_rectangle_first_fit_allocator.sv
// Top level of the grid rectangle first-fit allocator: sequencer, occupancy
// memory, shared row-union and window-search datapath. Depends on grfa_pkg.

// The block keeps one occupancy bit per slot in a memory of MAX_GRID_ROWS
// words, MAX_GRID_COLS bits each, plus one valid flip-flop per row so that
// reset and a clear beat free the whole grid by dropping all valid bits (no
// clearing pass; a row that is not valid reads as all free). An allocate beat
// scans candidate rows from the top. For each candidate row y the sequencer
// reads rows y..y+h-1 through the single read port and ORs them into a union
// word, then runs w shift-and steps over the free mask to find every column
// where w free slots start inside the grid, then picks the lowest such column.
// On a hit it reads, ORs in the placed columns and writes back rows y..y+h-1,
// then posts the result; if no candidate row is left it posts a miss. A clear
// beat or a request that cannot fit by size goes straight to posting the
// result. Input ready is high only while the sequencer is idle; a posted
// result waits in the output register and does not block the next input beat.
// Write the configuration registers only while the block is idle; values
// above the grid limits saturate.
module grid_rectangle_first_fit_allocator #(
    parameter int MAX_GRID_COLS = grfa_pkg::MAX_GRID_COLS_DEF,
    parameter int MAX_GRID_ROWS = grfa_pkg::MAX_GRID_ROWS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [grfa_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [grfa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  logic [grfa_pkg::SIZE_W-1:0]         i_req_width,
    input  logic [grfa_pkg::SIZE_W-1:0]         i_req_height,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic [grfa_pkg::CORNER_W-1:0]       o_corner_x,
    output logic [grfa_pkg::CORNER_W-1:0]       o_corner_y
);

    localparam int RW = (MAX_GRID_ROWS > 1) ? $clog2(MAX_GRID_ROWS) : 1;
    localparam int XW = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
    localparam int SW = grfa_pkg::SIZE_W;
    localparam int YW = grfa_pkg::ROW_CNT_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SW-1:0] r_grid_columns;
    logic [SW-1:0] r_grid_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= grfa_pkg::GRID_COLUMNS_RST;
            r_grid_rows    <= grfa_pkg::GRID_ROWS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                grfa_pkg::CFG_GRID_COLUMNS: r_grid_columns <= i_cfg_data;
                grfa_pkg::CFG_GRID_ROWS:    r_grid_rows    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Saturate to the store size. The row limit may exceed what the register
    // can hold, in which case the compare never fires.
    logic [SW-1:0] eff_cols;
    logic [SW-1:0] eff_rows;

    always_comb begin
        eff_cols = (r_grid_columns > SW'(MAX_GRID_COLS)) ? SW'(MAX_GRID_COLS)
                                                         : r_grid_columns;
        eff_rows = ({2'b00, r_grid_rows} > 9'(MAX_GRID_ROWS)) ? SW'(MAX_GRID_ROWS)
                                                              : r_grid_rows;
    end

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    grfa_pkg::t_state r_state, n_state;

    logic [SW-1:0]            r_w, n_w;         // request width
    logic [SW-1:0]            r_h, n_h;         // request height
    logic [SW-1:0]            r_cols, n_cols;   // grid width for this beat
    logic [SW-1:0]            r_rows, n_rows;   // grid height for this beat
    logic [YW-1:0]            r_y, n_y;         // candidate row
    logic [YW-1:0]            r_rd, n_rd;       // next row to read
    logic [YW-1:0]            r_wr, n_wr;       // row whose data returns now
    logic [SW-1:0]            r_left, n_left;   // reads still to issue
    logic                     r_pend, n_pend;   // read data returns this cycle
    logic [MAX_GRID_COLS-1:0] r_union, n_union; // OR of rows under candidate
    logic [MAX_GRID_COLS-1:0] r_free, n_free;   // shifted free mask
    logic [MAX_GRID_COLS-1:0] r_win, n_win;     // window-fit bits
    logic [SW-1:0]            r_k, n_k;         // shift steps left
    logic [XW-1:0]            r_x, n_x;         // chosen column
    logic [MAX_GRID_COLS-1:0] r_rect, n_rect;   // columns to mark
    logic                     r_res_found, n_res_found;

    // Output register
    logic                     r_out_valid, n_out_valid;
    logic                     r_found, n_found;
    logic [grfa_pkg::CORNER_W-1:0] r_cx, n_cx;
    logic [grfa_pkg::CORNER_W-1:0] r_cy, n_cy;

    // Memory side
    logic [MAX_GRID_COLS-1:0] r_mem [MAX_GRID_ROWS];
    logic [MAX_GRID_ROWS-1:0] r_row_valid;
    logic [MAX_GRID_COLS-1:0] r_rd_data;
    logic                     r_rd_vld;
    logic                     mem_re;
    logic                     mem_we;
    logic [MAX_GRID_COLS-1:0] mem_wdata;
    logic                     clear_all;

    logic                     in_acc;
    logic [MAX_GRID_COLS-1:0] col_mask;
    logic [MAX_GRID_COLS-1:0] rd_word;
    logic [MAX_GRID_COLS-1:0] low_bit;
    logic [XW-1:0]            low_idx;
    logic [YW-1:0]            x_end;
    logic [YW-1:0]            y_next;

    assign o_in_ready  = (r_state == grfa_pkg::ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_corner_x  = r_cx;
    assign o_corner_y  = r_cy;

    // Slot columns inside the grid of the current beat.
    always_comb begin
        for (int i = 0; i < MAX_GRID_COLS; i++) begin
            col_mask[i] = (YW'(i) < YW'(r_cols));
        end
    end

    // A row never written since the last clear reads as all free.
    assign rd_word = r_rd_vld ? r_rd_data : '0;

    // Lowest column where the window fits, and the columns it covers.
    always_comb begin
        low_bit = r_win & (~r_win + 1'b1);
        low_idx = '0;
        for (int i = 0; i < MAX_GRID_COLS; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | XW'(i);
            end
        end
        x_end  = YW'(low_idx) + YW'(r_w);
        y_next = r_y + 1'b1;
    end

    // ------------------------------------------------------------------
    // Next state and datapath
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_w         = r_w;
        n_h         = r_h;
        n_cols      = r_cols;
        n_rows      = r_rows;
        n_y         = r_y;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_left      = r_left;
        n_pend      = 1'b0;
        n_union     = r_union;
        n_free      = r_free;
        n_win       = r_win;
        n_k         = r_k;
        n_x         = r_x;
        n_rect      = r_rect;
        n_res_found = r_res_found;
        n_out_valid = r_out_valid && !i_out_ready;
        n_found     = r_found;
        n_cx        = r_cx;
        n_cy        = r_cy;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = rd_word | r_rect;
        clear_all   = 1'b0;

        // Shared read issue for the union and mark passes.
        if ((r_state == grfa_pkg::ST_ACC || r_state == grfa_pkg::ST_MARK)
                && r_left != '0) begin
            mem_re = 1'b1;
            n_rd   = r_rd + 1'b1;
            n_wr   = r_rd;
            n_left = r_left - 1'b1;
            n_pend = 1'b1;
        end

        unique case (r_state)
            grfa_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_w         = i_req_width;
                    n_h         = i_req_height;
                    n_cols      = eff_cols;
                    n_rows      = eff_rows;
                    n_y         = '0;
                    n_res_found = 1'b0;
                    if (i_mode == grfa_pkg::MODE_CLEAR) begin
                        clear_all = 1'b1;
                        n_state   = grfa_pkg::ST_RESULT;
                    end else if (i_req_width == '0 || i_req_height == '0
                            || i_req_width > eff_cols || i_req_height > eff_rows) begin
                        n_state = grfa_pkg::ST_RESULT;
                    end else begin
                        n_rd    = '0;
                        n_left  = i_req_height;
                        n_union = '0;
                        n_state = grfa_pkg::ST_ACC;
                    end
                end
            end

            grfa_pkg::ST_ACC: begin
                if (r_pend) begin
                    n_union = r_union | rd_word;
                end
                // Last read lands this cycle: seed the window search.
                if (r_left == '0) begin
                    n_free  = ~(r_union | rd_word) & col_mask;
                    n_win   = '1;
                    n_k     = r_w;
                    n_state = grfa_pkg::ST_SHIFT;
                end
            end

            grfa_pkg::ST_SHIFT: begin
                n_win  = r_win & r_free;
                n_free = r_free >> 1;
                n_k    = r_k - 1'b1;
                if (r_k == SW'(1)) begin
                    n_state = grfa_pkg::ST_PICK;
                end
            end

            grfa_pkg::ST_PICK: begin
                if (r_win != '0) begin
                    n_x = low_idx;
                    for (int i = 0; i < MAX_GRID_COLS; i++) begin
                        n_rect[i] = (YW'(i) >= YW'(low_idx)) && (YW'(i) < x_end);
                    end
                    n_rd    = r_y;
                    n_left  = r_h;
                    n_state = grfa_pkg::ST_MARK;
                end else if (y_next + YW'(r_h) > YW'(r_rows)) begin
                    n_state = grfa_pkg::ST_RESULT;
                end else begin
                    n_y     = y_next;
                    n_rd    = y_next;
                    n_left  = r_h;
                    n_union = '0;
                    n_state = grfa_pkg::ST_ACC;
                end
            end

            grfa_pkg::ST_MARK: begin
                // Write back each row as its data returns.
                if (r_pend) begin
                    mem_we = 1'b1;
                end
                if (r_left == '0) begin
                    n_res_found = 1'b1;
                    n_state     = grfa_pkg::ST_RESULT;
                end
            end

            grfa_pkg::ST_RESULT: begin
                // Hold until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_found     = r_res_found;
                    n_cx        = r_res_found ? grfa_pkg::CORNER_W'(r_x) : '0;
                    n_cy        = r_res_found ? grfa_pkg::CORNER_W'(r_y) : '0;
                    n_state     = grfa_pkg::ST_IDLE;
                end
            end

            default: n_state = grfa_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= grfa_pkg::ST_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w         <= n_w;
        r_h         <= n_h;
        r_cols      <= n_cols;
        r_rows      <= n_rows;
        r_y         <= n_y;
        r_rd        <= n_rd;
        r_wr        <= n_wr;
        r_left      <= n_left;
        r_union     <= n_union;
        r_free      <= n_free;
        r_win       <= n_win;
        r_k         <= n_k;
        r_x         <= n_x;
        r_rect      <= n_rect;
        r_res_found <= n_res_found;
        r_found     <= n_found;
        r_cx        <= n_cx;
        r_cy        <= n_cy;
    end

    // Row valid bits: drop all on reset or clear, set on write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (clear_all) begin
            r_row_valid <= '0;
        end else if (mem_we) begin
            r_row_valid[r_wr[RW-1:0]] <= 1'b1;
        end
    end

    // Occupancy memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr[RW-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_rd[RW-1:0]];
            r_rd_vld  <= r_row_valid[r_rd[RW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_corner_x == '0 && o_corner_y == '0))
        else $error("miss result carries a nonzero corner");

    a_write_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_wr < YW'(r_rows) && r_wr >= r_y && r_wr < r_y + YW'(r_h)))
        else $error("write-back outside the placed rectangle rows");

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode == grfa_pkg::MODE_CLEAR) |=> (r_row_valid == '0))
        else $error("clear beat left rows marked valid");

    a_fit_in_cols: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == grfa_pkg::ST_MARK) |-> ((r_rect & ~col_mask) == '0 && r_rect != '0))
        else $error("placed columns fall outside the grid");

endmodule

FILE: verif/tb_grid_rectangle_first_fit_allocator.sv
// Self-checking testbench for grid_rectangle_first_fit_allocator: random and directed
// allocate and clear beats, with a first-fit occupancy predictor in a scoreboard class.
// Depends on hdl/grfa_pkg.sv and hdl/grid_rectangle_first_fit_allocator.sv.
module tb_grid_rectangle_first_fit_allocator;

    timeunit 1ns;
    timeprecision 1ps;

    // Largest grid the occupancy store can hold (default sizing of the block).
    localparam int GRID_LIMIT    = grfa_pkg::MAX_GRID_COLS_DEF;
    // The watchdog limit covers the longest single search on a 64x64 grid, with
    // room for the receiver's long hold-off and the sender's long gaps on top.
    localparam int STALL_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASES        = 12;

    // One result beat as the block should present it.
    typedef struct packed {
        logic                              found;
        logic [grfa_pkg::CORNER_W-1:0]     corner_x;
        logic [grfa_pkg::CORNER_W-1:0]     corner_y;
    } t_placement;

    // Occupancy predictor plus the queue of placements still owed by the block.
    class t_placement_scoreboard;
        logic [GRID_LIMIT-1:0] occupancy [GRID_LIMIT];
        int                    cols_cfg;
        int                    rows_cfg;
        t_placement            owed_q [$];
        int                    mismatches;

        function new();
            foreach (occupancy[r]) occupancy[r] = '0;
            cols_cfg   = GRID_LIMIT;
            rows_cfg   = GRID_LIMIT;
            mismatches = 0;
        endfunction

        function void set_register(logic [grfa_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [grfa_pkg::CFG_DATA_W-1:0] data);
            if (idx == grfa_pkg::CFG_GRID_COLUMNS)
                cols_cfg = data;
            else
                rows_cfg = data;
        endfunction

        // Work out the placement for one accepted request and update occupancy.
        function void note_request(logic mode, logic [grfa_pkg::SIZE_W-1:0] w,
                                   logic [grfa_pkg::SIZE_W-1:0] h);
            t_placement            p;
            int                    cols;
            int                    rows;
            logic [GRID_LIMIT-1:0] span;
            bit                    clash;
            p    = '0;
            cols = (cols_cfg > GRID_LIMIT) ? GRID_LIMIT : cols_cfg;
            rows = (rows_cfg > GRID_LIMIT) ? GRID_LIMIT : rows_cfg;
            if (mode == grfa_pkg::MODE_CLEAR) begin
                foreach (occupancy[r]) occupancy[r] = '0;
            end else if (w != 0 && h != 0 && w <= cols && h <= rows) begin
                span = (w >= GRID_LIMIT) ? '1 : ((GRID_LIMIT'(1) << w) - 1);
                // Scan corners row by row, then column by column; take the first free one.
                for (int y = 0; y + h <= rows && !p.found; y++) begin
                    for (int x = 0; x + w <= cols && !p.found; x++) begin
                        clash = 0;
                        for (int r = y; r < y + h; r++)
                            if ((occupancy[r] & (span << x)) != '0) clash = 1;
                        if (!clash) begin
                            for (int r = y; r < y + h; r++)
                                occupancy[r] |= span << x;
                            p.found    = 1'b1;
                            p.corner_x = x[grfa_pkg::CORNER_W-1:0];
                            p.corner_y = y[grfa_pkg::CORNER_W-1:0];
                        end
                    end
                end
            end
            owed_q.push_back(p);
        endfunction

        function void report(string what, t_placement want, t_placement got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s: expected found=%0b x=%0d y=%0d, got found=%0b x=%0d y=%0d",
                         $realtime, what, want.found, want.corner_x, want.corner_y,
                         got.found, got.corner_x, got.corner_y);
        endfunction

        function void check_result(t_placement got);
            t_placement want;
            if (owed_q.size() == 0) begin
                report("result with nothing owed", '0, got);
            end else begin
                want = owed_q.pop_front();
                if (got.found !== want.found || got.corner_x !== want.corner_x ||
                    got.corner_y !== want.corner_y)
                    report("placement mismatch", want, got);
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function int failures();
            return mismatches + owed_q.size();
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n      = 1'b0;
    logic                                cfg_we       = 1'b0;
    logic [grfa_pkg::CFG_INDEX_W-1:0]    cfg_index    = grfa_pkg::CFG_GRID_COLUMNS;
    logic [grfa_pkg::CFG_DATA_W-1:0]     cfg_data     = '0;
    logic                                in_valid     = 1'b0;
    logic                                o_in_ready;
    logic                                req_mode     = grfa_pkg::MODE_ALLOC;
    logic [grfa_pkg::SIZE_W-1:0]         req_width    = '0;
    logic [grfa_pkg::SIZE_W-1:0]         req_height   = '0;
    logic                                o_out_valid;
    logic                                out_ready    = 1'b0;
    logic                                o_found;
    logic [grfa_pkg::CORNER_W-1:0]       o_corner_x;
    logic [grfa_pkg::CORNER_W-1:0]       o_corner_y;

    // Phase-wide switches for the sender and the receiver.
    bit steady   = 1'b0;   // no idling on either side
    bit hold_off = 1'b0;   // receiver holds ready low once, then clears the switch

    int idle_cycles = 0;

    t_placement_scoreboard sb = new();

    grid_rectangle_first_fit_allocator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (req_mode),
        .i_req_width  (req_width),
        .i_req_height (req_height),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_found      (o_found),
        .o_corner_x   (o_corner_x),
        .o_corner_y   (o_corner_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Monitor: sample both handshakes at the rising edge, feed the scoreboard and
    // run the watchdog on cycles where neither side moves a beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready)
                sb.note_request(req_mode, req_width, req_height);
            if (o_out_valid && out_ready)
                sb.check_result('{o_found, o_corner_x, o_corner_y});
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $realtime, STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver: ready pattern changes only at falling edges. Most stalls are short,
    // a few long; steady phases keep ready high; one long hold-off fills the block.
    initial begin
        int span;
        int roll;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_off = 1'b0;
            end else if (steady || !i_rst_n) begin
                out_ready <= 1'b1;
            end else begin
                roll = $urandom_range(99);
                if (roll < 70) begin
                    out_ready <= 1'b1;
                    span = 1;
                end else if (roll < 95) begin
                    out_ready <= 1'b0;
                    span = $urandom_range(3, 1);
                end else begin
                    out_ready <= 1'b0;
                    span = $urandom_range(80, 20);
                end
                repeat (span - 1) @(negedge i_clk);
            end
        end
    end

    // Offer one request beat after a random gap and hold it until accepted.
    task automatic send_request(logic mode, logic [grfa_pkg::SIZE_W-1:0] w,
                                logic [grfa_pkg::SIZE_W-1:0] h);
        int gap;
        int roll;
        roll = $urandom_range(99);
        if (steady || roll < 65)
            gap = 0;
        else if (roll < 90)
            gap = $urandom_range(3, 1);
        else
            gap = $urandom_range(60, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        req_mode   <= mode;
        req_width  <= w;
        req_height <= h;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid and wait until every owed placement has come back.
    task automatic quiesce();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Write one register while the block is idle; mirror it in the predictor.
    task automatic write_register(logic [grfa_pkg::CFG_INDEX_W-1:0] idx,
                                  logic [grfa_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        sb.set_register(idx, data);
    endtask

    task automatic set_grid(int cols, int rows);
        quiesce();
        write_register(grfa_pkg::CFG_GRID_COLUMNS, cols[grfa_pkg::CFG_DATA_W-1:0]);
        write_register(grfa_pkg::CFG_GRID_ROWS, rows[grfa_pkg::CFG_DATA_W-1:0]);
    endtask

    // Mostly small sizes so the searches stay short; some zero, some out of range,
    // some up to the whole grid.
    function automatic logic [grfa_pkg::SIZE_W-1:0] pick_size(int grid_span);
        int roll;
        roll = $urandom_range(99);
        if (roll < 4)
            return '0;
        if (roll < 11)
            return grfa_pkg::SIZE_W'($urandom_range(127));
        if (roll < 22 && grid_span > 0)
            return grfa_pkg::SIZE_W'($urandom_range(grid_span, 1));
        return grfa_pkg::SIZE_W'($urandom_range(4, 1));
    endfunction

    initial begin
        // Column and row settings per phase; -1 picks a random value.
        int phase_cols  [PHASES] = '{64, 8, 1, 127, 0, 16, 64, 1, 5, -1, -1, -1};
        int phase_rows  [PHASES] = '{64, 8, 1, 127, 16, 0, 1, 64, 3, -1, -1, -1};
        int phase_items [PHASES] = '{160, 160, 60, 150, 40, 40, 100, 100, 150, 160, 160, 160};
        int cols;
        int rows;
        logic mode;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on the reset grid of 64 x 64.
        send_request(grfa_pkg::MODE_ALLOC, 7'd1, 7'd1);
        send_request(grfa_pkg::MODE_ALLOC, 7'd64, 7'd1);
        send_request(grfa_pkg::MODE_ALLOC, 7'd1, 7'd64);
        send_request(grfa_pkg::MODE_ALLOC, 7'd0, 7'd5);     // zero width
        send_request(grfa_pkg::MODE_ALLOC, 7'd5, 7'd0);     // zero height
        send_request(grfa_pkg::MODE_ALLOC, 7'd65, 7'd1);    // wider than the grid
        send_request(grfa_pkg::MODE_ALLOC, 7'd1, 7'd65);    // taller than the grid
        send_request(grfa_pkg::MODE_ALLOC, 7'd127, 7'd127);
        send_request(grfa_pkg::MODE_ALLOC, 7'd63, 7'd1);
        send_request(grfa_pkg::MODE_CLEAR, 7'd127, 7'd127);
        send_request(grfa_pkg::MODE_ALLOC, 7'd64, 7'd64);   // whole grid
        send_request(grfa_pkg::MODE_ALLOC, 7'd1, 7'd1);     // grid full
        send_request(grfa_pkg::MODE_CLEAR, 7'd0, 7'd0);
        send_request(grfa_pkg::MODE_ALLOC, 7'd7, 7'd9);
        send_request(grfa_pkg::MODE_ALLOC, 7'd64, 7'd63);
        // Empty grid: nothing can be placed.
        set_grid(0, 64);
        send_request(grfa_pkg::MODE_ALLOC, 7'd1, 7'd1);
        set_grid(64, 0);
        send_request(grfa_pkg::MODE_ALLOC, 7'd1, 7'd1);
        // Settings above the limit saturate to 64.
        set_grid(127, 127);
        send_request(grfa_pkg::MODE_ALLOC, 7'd64, 7'd1);
        // Tiny grid, then grow it without a clear: old bits keep their places.
        set_grid(3, 2);
        send_request(grfa_pkg::MODE_ALLOC, 7'd2, 7'd2);
        send_request(grfa_pkg::MODE_ALLOC, 7'd2, 7'd2);
        send_request(grfa_pkg::MODE_ALLOC, 7'd1, 7'd2);
        set_grid(5, 4);
        send_request(grfa_pkg::MODE_ALLOC, 7'd2, 7'd2);
        send_request(grfa_pkg::MODE_ALLOC, 7'd1, 7'd1);

        // Random phases. Occupancy carries over between phases, so each new grid
        // also sees slots left over from the previous one.
        for (int p = 0; p < PHASES; p++) begin
            cols = (phase_cols[p] < 0) ? $urandom_range(127) : phase_cols[p];
            rows = (phase_rows[p] < 0) ? $urandom_range(127) : phase_rows[p];
            set_grid(cols, rows);
            if (cols > GRID_LIMIT) cols = GRID_LIMIT;
            if (rows > GRID_LIMIT) rows = GRID_LIMIT;
            steady = (p % 4 == 3);
            // Small grid, fast searches: starve the output so the input backs up.
            if (p == 1) hold_off = 1'b1;
            for (int n = 0; n < phase_items[p]; n++) begin
                mode = ($urandom_range(99) < 4) ? grfa_pkg::MODE_CLEAR : grfa_pkg::MODE_ALLOC;
                send_request(mode, pick_size(cols), pick_size(rows));
            end
        end
        steady = 1'b0;

        quiesce();
        repeat (50) @(posedge i_clk);
        if (sb.failures() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/grfa_pkg.sv
hdl/grid_rectangle_first_fit_allocator.sv
verif/tb_grid_rectangle_first_fit_allocator.sv
